// File: src/fba_pkg.sv
`default_nettype none

package fba_pkg;

	localparam int FRAME_W = 12;
	localparam int COUNT_W = 13;
	localparam logic [COUNT_W-1:0] FRAMES_RESET = 13'h1000;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_MARK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_IGNORED  = 2'd1,
		ST_NO_FRAME = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [FRAME_W-1:0] frame_number;
		logic               entry_present;
	} fba_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_out;
		logic               bit_was_set;
		status_t            status;
	} fba_rsp_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frames_in_use;
	} fba_cfg_t;

endpackage

`default_nettype wire

// File: src/fba_chan.sv
`default_nettype none

interface fba_chan #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/frame_bitmap_allocator.sv
// Flow: test, free and mark read the item's bitmap word, then register the result;
//   allocate also scans at most limit bitmap words first (none if entry_present or limit is 0).
// Throughput: one item at a time; the allocate scan is set by the single read port
//   of the bitmap RAM (one word per cycle).
// Reset: arst_n clears control state, then a clearing pass writes zero to every
//   bitmap word; req.ready stays low until it ends, cfg writes are taken.
`default_nettype none

module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	fba_chan.sink   req,
	fba_chan.source rsp,
	fba_chan.sink   cfg
);

	import fba_pkg::*;

	// WORD_BITS is a power of two; MAX_FRAMES is a multiple of it.
	localparam int FRAME_WORDS = MAX_FRAMES / WORD_BITS;
	localparam int BW          = $clog2(WORD_BITS);
	localparam int AW          = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int LW          = $clog2(FRAME_WORDS + 1);

	// Lowest clear bit of a word; only used when the word is not full.
	function automatic logic [BW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [BW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BW'(i);
			end
		end
		return idx;
	endfunction

	// Control state
	state_t           state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [COUNT_W-1:0] frames_q;
	logic             rsp_valid_q;

	// Item held while it is worked on
	cmd_t             cmd_q;
	logic [FRAME_W-1:0] fn_q;
	logic             present_q;
	logic             in_range_q;
	logic [AW-1:0]    fn_word_q;
	logic [BW-1:0]    fn_bit_q;
	logic [LW-1:0]    limit_q;
	logic [AW-1:0]    scan_q;

	// Result waiting for the output register
	logic [FRAME_W-1:0] res_frame_q;
	logic             res_was_q;
	status_t          res_status_q;
	fba_rsp_t         rsp_data_q;

	// Bitmap RAM ports
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	// Decode of the incoming item and of the working word
	logic [AW-1:0]    fn_word_in;
	logic             fn_in_range;
	logic [COUNT_W-1:0] limit_raw;
	logic [LW-1:0]    limit_in;
	logic [WORD_BITS-1:0] fn_mask;
	logic             was_fn;
	logic             word_full;
	logic [BW-1:0]    zero_idx;
	logic [AW:0]      scan_next;
	logic             scan_last;
	logic             req_take;
	logic             rsp_load;
	logic             fn_write;

	assign fn_word_in  = AW'(req.data.frame_number >> BW);
	assign fn_in_range = 32'(req.data.frame_number) < 32'(MAX_FRAMES);
	assign limit_raw   = frames_q >> BW;
	// Saturate the search bound to the bitmap depth
	assign limit_in    = (32'(limit_raw) > 32'(FRAME_WORDS)) ? LW'(FRAME_WORDS) : LW'(limit_raw);

	assign fn_mask     = {{(WORD_BITS-1){1'b0}}, 1'b1} << fn_bit_q;
	// A frame beyond the bitmap reads as free
	assign was_fn      = in_range_q & rd_data[fn_bit_q];
	assign word_full   = &rd_data;
	assign zero_idx    = lowest_zero(rd_data);
	assign scan_next   = (AW+1)'(scan_q) + 1'b1;
	assign scan_last   = scan_next == (AW+1)'(limit_q);

	assign req_take    = req.valid && req.ready;
	assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign fn_write    = in_range_q &&
		((cmd_q == CMD_FREE && present_q) || cmd_q == CMD_MARK);

	assign req.ready   = state_q == S_IDLE;
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.data    = rsp_data_q;

	fba_word_ram #(
		.WIDTH  (WORD_BITS),
		.DEPTH  (FRAME_WORDS),
		.ADDR_W (AW)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Read address: the item's own word on accept, then the scan words.
	// Outside the clearing pass, writes never hit a word that is read in the same cycle, so no forwarding.
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = fn_word_in;
			S_LOOK:  rd_addr = '0;
			S_SCAN:  rd_addr = scan_next[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// Write back the modified word, or zero a word during the clearing pass
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fn_word_q;
		wr_data = rd_data;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_LOOK: begin
				wr_en   = fn_write;
				wr_addr = fn_word_q;
				wr_data = (cmd_q == CMD_FREE) ? (rd_data & ~fn_mask) : (rd_data | fn_mask);
			end
			S_SCAN: begin
				wr_en   = !word_full;
				wr_addr = scan_q;
				wr_data = rd_data | ({{(WORD_BITS-1){1'b0}}, 1'b1} << zero_idx);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(FRAME_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (cmd_q == CMD_ALLOC && !present_q && limit_q != '0) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (!word_full || scan_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			frames_q    <= FRAMES_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				frames_q <= cfg.data.frames_in_use;
			end
			// Hold the result until taken; reload as soon as the slot frees
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q      <= req.data.cmd;
			fn_q       <= req.data.frame_number;
			present_q  <= req.data.entry_present;
			in_range_q <= fn_in_range;
			fn_word_q  <= fn_word_in;
			fn_bit_q   <= req.data.frame_number[BW-1:0];
			limit_q    <= limit_in;
		end

		case (state_q)
			S_LOOK: begin
				res_frame_q  <= fn_q;
				res_was_q    <= was_fn;
				scan_q       <= '0;
				res_status_q <= ST_DONE;
				if (cmd_q == CMD_ALLOC) begin
					if (present_q) begin
						res_status_q <= ST_IGNORED;
					end else if (limit_q == '0) begin
						res_status_q <= ST_NO_FRAME;
					end
				end else if (cmd_q == CMD_FREE && !present_q) begin
					res_status_q <= ST_IGNORED;
				end
			end
			S_SCAN: begin
				if (!word_full) begin
					// A free bit was clear before the step
					res_frame_q  <= FRAME_W'({scan_q, zero_idx});
					res_was_q    <= 1'b0;
					res_status_q <= ST_DONE;
				end else if (scan_last) begin
					res_status_q <= ST_NO_FRAME;
				end else begin
					scan_q <= scan_next[AW-1:0];
				end
			end
			default: begin
			end
		endcase

		if (rsp_load) begin
			rsp_data_q.frame_out   <= res_frame_q;
			rsp_data_q.bit_was_set <= res_was_q;
			rsp_data_q.status      <= res_status_q;
		end
	end

endmodule

`default_nettype wire

// File: src/fba_word_ram.sv
`default_nettype none

module fba_word_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: src/fba_checker.sv
`default_nettype none

module fba_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input fba_pkg::fba_rsp_t rsp_data
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped or changed while stalled");

	// One item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while another is in work");

	// A result needs the bitmap read first, so it cannot show the next cycle
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared before the bitmap word was read");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
